[design/turn_arc_turn_planner_core_defines.svh]
// assertion macros for the turn-arc-turn planner checker
`ifndef TURN_ARC_TURN_PLANNER_CORE_DEFINES_SVH
`define TURN_ARC_TURN_PLANNER_CORE_DEFINES_SVH

// clocked assertion with reset disable
`define TATP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// assertion that only applies while a result is shown
`define TATP_ASSERT_OUT(lbl, prop, msg) \
	`TATP_ASSERT(lbl, out_valid |-> (prop), msg)

`endif

[design/tatp_pkg.sv]
// types, constants and helpers for the turn-arc-turn planner
package tatp_pkg;

	localparam int CORDIC_W  = 34;
	localparam int ATAN_LEN  = 24;
	localparam int ROOT_BITS = 16;
	localparam int PROD_W    = 48;
	localparam int REM_W     = 47;
	localparam int TRIAL_W   = 66;

	localparam logic [15:0] HALF_QUARTER = 16'd16384;
	localparam logic [15:0] HALF_TURN    = 16'd32768;
	localparam logic [15:0] POWER_ONE    = 16'd16384;
	localparam logic [15:0] POWER_MIN    = 16'h8000;
	localparam logic [15:0] Q_SAT        = 16'd49152;
	localparam logic [15:0] WIDTH_RESET  = 16'd256;

	typedef logic signed [CORDIC_W-1:0] cordic_word_t;

	// atan(2^-i) in Q2.30 half-turns
	localparam cordic_word_t ATAN_Q30 [ATAN_LEN] = '{
		34'sd268435456, 34'sd158466703, 34'sd83729454, 34'sd42502378,
		34'sd21333666, 34'sd10677233, 34'sd5339919, 34'sd2670123,
		34'sd1335082, 34'sd667543, 34'sd333772, 34'sd166886,
		34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430,
		34'sd5215, 34'sd2608, 34'sd1304, 34'sd652,
		34'sd326, 34'sd163, 34'sd81, 34'sd41
	};

	localparam cordic_word_t QUARTER_Q30 = 34'sd536870912;

	typedef struct packed {
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic signed [15:0] heading_start;
		logic signed [15:0] heading_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        first_turn;
		logic [15:0]        second_turn;
		logic signed [15:0] drive_power;
		logic               zero_distance;
	} out_item_t;

	// payload of one cordic stage
	typedef struct packed {
		cordic_word_t x;
		cordic_word_t y;
		cordic_word_t z;
		logic         zero;
		logic [15:0]  hs;
		logic [15:0]  he;
		logic [30:0]  sq_x;
		logic [30:0]  sq_y;
	} cordic_st_t;

	// payload of one root stage
	typedef struct packed {
		logic [ROOT_BITS-1:0] q;
		logic [PROD_W-1:0]    p;
		logic [REM_W-1:0]     r;
		logic [31:0]          s;
		logic [15:0]          bearing;
		logic [15:0]          hs;
		logic [15:0]          he;
		logic                 zero;
	} root_st_t;

	// shortest turn magnitude between two wrapped angles
	function automatic logic [15:0] turn_mag(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] d;
		d = a - b;
		if (d > HALF_TURN)
			d = 16'd0 - d;
		return d;
	endfunction

endpackage

[design/turn_arc_turn_planner_core.sv]
// turn-arc-turn planner: cordic bearing, exact width/distance root, side choice
//
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_wdata (robot width, Q8.8)
//  in      | in        | in_valid, in_stall | in_item (tatp_pkg::in_item_t)
//  out     | out       | out_valid, out_stall | out_item (tatp_pkg::out_item_t)
//
// one transaction per cycle while the result is not stalled
// pipe: pre-rotation, vectoring stages, setup, sixteen root-search stages, output
// all stages advance together; a stalled result holds the whole pipe
// arst_n clears all valid bits and sets robot width to 1.0
module turn_arc_turn_planner_core #(
	parameter int ROTATION_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  tatp_pkg::in_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output tatp_pkg::out_item_t out_item
);

	localparam int NS = ROTATION_STAGES;
	localparam int NR = tatp_pkg::ROOT_BITS;

	logic [15:0] robot_width_q;
	logic        adv;

	tatp_pkg::cordic_st_t cordic_s [NS+1];
	logic                 cordic_valid_s [NS+1];
	tatp_pkg::root_st_t   root_s [NR+1];
	logic                 root_valid_s [NR+1];
	logic                 out_valid_q;
	tatp_pkg::out_item_t  out_item_q;

	// width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			robot_width_q <= tatp_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			robot_width_q <= cfg_wdata;
		end
	end

	// global advance
	assign adv       = !(out_valid_q && out_stall);
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// pre-rotation into the right half plane, squares
	tatp_pkg::cordic_st_t pre;
	logic signed [31:0]   sqx_full, sqy_full;
	always_comb begin
		tatp_pkg::cordic_word_t xi, yi;
		xi = tatp_pkg::cordic_word_t'(in_item.target_x) <<< 14;
		yi = tatp_pkg::cordic_word_t'(in_item.target_y) <<< 14;
		sqx_full = in_item.target_x * in_item.target_x;
		sqy_full = in_item.target_y * in_item.target_y;
		pre = '0;
		pre.x = xi;
		pre.y = yi;
		pre.z = '0;
		if (xi < 0) begin
			if (yi >= 0) begin
				pre.x = yi;
				pre.y = -xi;
				pre.z = tatp_pkg::QUARTER_Q30;
			end else begin
				pre.x = -yi;
				pre.y = xi;
				pre.z = -tatp_pkg::QUARTER_Q30;
			end
		end
		pre.zero = (in_item.target_x == 16'sd0) && (in_item.target_y == 16'sd0);
		pre.hs   = in_item.heading_start;
		pre.he   = in_item.heading_end;
		pre.sq_x = sqx_full[30:0];
		pre.sq_y = sqy_full[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cordic_valid_s[0] <= 1'b0;
		end else if (adv) begin
			cordic_valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			cordic_s[0] <= pre;
	end

	// vectoring stages
	for (genvar k = 0; k < NS; k++) begin : g_cordic
		tatp_pkg::cordic_st_t nxt;
		always_comb begin
			tatp_pkg::cordic_word_t xs, ys;
			xs  = cordic_s[k].x >>> k;
			ys  = cordic_s[k].y >>> k;
			nxt = cordic_s[k];
			if (cordic_s[k].y >= 0) begin
				nxt.x = cordic_s[k].x + ys;
				nxt.y = cordic_s[k].y - xs;
				nxt.z = cordic_s[k].z + tatp_pkg::ATAN_Q30[k];
			end else begin
				nxt.x = cordic_s[k].x - ys;
				nxt.y = cordic_s[k].y + xs;
				nxt.z = cordic_s[k].z - tatp_pkg::ATAN_Q30[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cordic_valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				cordic_valid_s[k+1] <= cordic_valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				cordic_s[k+1] <= nxt;
		end
	end

	// bearing rounding, distance squared, width squared
	tatp_pkg::root_st_t setup;
	always_comb begin
		tatp_pkg::cordic_word_t zr;
		logic [22:0]            n;
		logic [45:0]            n2;
		zr = cordic_s[NS].z + tatp_pkg::cordic_word_t'(16384);
		n  = {robot_width_q, 7'b0};
		n2 = n * n;
		setup         = '0;
		setup.q       = '0;
		setup.p       = '0;
		setup.r       = tatp_pkg::REM_W'(n2);
		setup.s       = 32'(cordic_s[NS].sq_x) + 32'(cordic_s[NS].sq_y);
		setup.bearing = cordic_s[NS].zero ? 16'd0 : zr[30:15];
		setup.hs      = cordic_s[NS].hs;
		setup.he      = cordic_s[NS].he;
		setup.zero    = cordic_s[NS].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_s[0] <= 1'b0;
		end else if (adv) begin
			root_valid_s[0] <= cordic_valid_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			root_s[0] <= setup;
	end

	// one quotient bit a stage: keep r = n2 - q*q*s and p = q*s
	for (genvar j = 0; j < NR; j++) begin : g_root
		localparam int B = NR - 1 - j;
		tatp_pkg::root_st_t nxt;
		always_comb begin
			logic [tatp_pkg::TRIAL_W-1:0] trial;
			trial = (tatp_pkg::TRIAL_W'(root_s[j].p) << (B + 1))
				+ (tatp_pkg::TRIAL_W'(root_s[j].s) << (2 * B));
			nxt = root_s[j];
			if (trial <= tatp_pkg::TRIAL_W'(root_s[j].r)) begin
				nxt.q[B] = 1'b1;
				nxt.r    = root_s[j].r - tatp_pkg::REM_W'(trial);
				nxt.p    = root_s[j].p + (tatp_pkg::PROD_W'(root_s[j].s) << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_valid_s[j+1] <= 1'b0;
			end else if (adv) begin
				root_valid_s[j+1] <= root_valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv)
				root_s[j+1] <= nxt;
		end
	end

	// side choice and power saturation
	tatp_pkg::out_item_t res;
	always_comb begin
		logic [15:0] left, right, l1, l2, r1, r2, qs;
		logic [16:0] lsum, rsum;
		left  = root_s[NR].bearing - tatp_pkg::HALF_QUARTER;
		right = root_s[NR].bearing + tatp_pkg::HALF_QUARTER;
		l1 = tatp_pkg::turn_mag(root_s[NR].hs, left);
		l2 = tatp_pkg::turn_mag(right, root_s[NR].he);
		r1 = tatp_pkg::turn_mag(root_s[NR].hs, right);
		r2 = tatp_pkg::turn_mag(left, root_s[NR].he);
		lsum = 17'(l1) + 17'(l2);
		rsum = 17'(r1) + 17'(r2);
		qs = (root_s[NR].q > tatp_pkg::Q_SAT) ? tatp_pkg::Q_SAT : root_s[NR].q;
		res = '0;
		if (lsum < rsum) begin
			res.first_turn  = l1;
			res.second_turn = l2;
		end else begin
			res.first_turn  = r1;
			res.second_turn = r2;
		end
		res.drive_power   = root_s[NR].zero ? tatp_pkg::POWER_MIN
			: (tatp_pkg::POWER_ONE - qs);
		res.zero_distance = root_s[NR].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= root_valid_s[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_item_q <= res;
	end

endmodule

[design/tatp_checker.sv]
// port checker for the turn-arc-turn planner and its bind
`include "turn_arc_turn_planner_core_defines.svh"

module tatp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input tatp_pkg::out_item_t out_item
);

	// a stalled result transaction holds
	`TATP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed while stalled")
	// input is held back only behind a stalled result
	`TATP_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a stalled result")
	// zero distance forces minimum power
	`TATP_ASSERT_OUT(a_zero_power, !out_item.zero_distance || out_item.drive_power == -16'sd32768, "zero distance without minimum power")
	// turn magnitudes and power stay in range
	`TATP_ASSERT_OUT(a_ranges, out_item.first_turn <= 16'd32768 && out_item.second_turn <= 16'd32768 && out_item.drive_power <= 16'sd16384, "result out of range")

endmodule

bind turn_arc_turn_planner_core tatp_checker u_tatp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
